// ===== sv/u32dm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// u32dm_pkg
// Shared widths, stage counts and the work item carried down the pipeline of
// the unsigned 32-bit division magic generator.
// ----------------------------------------------------------------------------
package u32dm_pkg;

    localparam int WORD_W             = 32;
    localparam int SHIFT_W            = 5;
    localparam int DIV_BITS_PER_STAGE = 2;
    localparam int DIV_STAGE_COUNT    = WORD_W / DIV_BITS_PER_STAGE;
    localparam int IN_TDATA_W         = 32;
    localparam int OUT_TDATA_W        = 40;

    // Partial remainder seed: top word of the normalised dividend 2^63.
    localparam logic [WORD_W-1:0] REM_SEED = {1'b1, {(WORD_W-1){1'b0}}};

    typedef struct packed {
        logic [WORD_W-1:0]  dn;     // divisor shifted so that bit 31 is set
        logic [WORD_W-1:0]  rem;    // partial remainder, scaled like dn
        logic [WORD_W-1:0]  quo;    // quotient bits gathered so far
        logic [SHIFT_W-1:0] shift;  // floor(log2(divisor))
        logic               pow2;
        logic               zero;
    } t_work;

    typedef struct packed {
        logic [WORD_W-1:0]  magic;
        logic [SHIFT_W-1:0] shift;
        logic               add_marker;
        logic               zero_error;
    } t_result;

endpackage
`default_nettype wire

// ===== sv/u32dm_norm.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// u32dm_norm
// Two-stage normaliser: classifies the divisor, counts leading zeros and
// shifts the divisor up until its top bit is set.
// ----------------------------------------------------------------------------
module u32dm_norm (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    output logic                                 o_ready,
    input  wire logic [u32dm_pkg::WORD_W-1:0]    i_divisor,
    output logic                                 o_valid,
    input  wire logic                            i_ready,
    output u32dm_pkg::t_work                     o_work
);

    logic                         r1_valid;
    logic [u32dm_pkg::WORD_W-1:0] r1_d;
    logic [1:0]                   r1_lz;
    logic                         r1_pow2;
    logic                         r1_zero;

    logic [u32dm_pkg::WORD_W-1:0] n1_d;
    logic [1:0]                   n1_lz;
    logic                         n1_pow2;
    logic                         n1_zero;
    logic [u32dm_pkg::WORD_W-1:0] d16;
    logic [u32dm_pkg::WORD_W-1:0] dm1;

    logic                         r2_valid;
    u32dm_pkg::t_work             r2_work;
    u32dm_pkg::t_work             n2_work;
    logic [u32dm_pkg::WORD_W-1:0] d4;
    logic [u32dm_pkg::WORD_W-1:0] d2;
    logic [2:0]                   lz_lo;

    logic ready1;
    logic ready2;

    assign ready2  = !r2_valid || i_ready;
    assign ready1  = !r1_valid || ready2;
    assign o_ready = ready1;
    assign o_valid = r2_valid;
    assign o_work  = r2_work;

    // Coarse part: shift by 16 and 8
    always_comb begin
        dm1      = i_divisor - u32dm_pkg::WORD_W'(1);
        n1_zero  = (i_divisor == '0);
        n1_pow2  = !n1_zero && ((i_divisor & dm1) == '0);
        n1_lz[1] = (i_divisor[31:16] == '0);
        d16      = n1_lz[1] ? {i_divisor[15:0], 16'h0000} : i_divisor;
        n1_lz[0] = (d16[31:24] == '0);
        n1_d     = n1_lz[0] ? {d16[23:0], 8'h00} : d16;
    end

    // Fine part: shift by 4, 2 and 1
    always_comb begin
        lz_lo[2] = (r1_d[31:28] == '0);
        d4       = lz_lo[2] ? {r1_d[27:0], 4'h0} : r1_d;
        lz_lo[1] = (d4[31:30] == '0);
        d2       = lz_lo[1] ? {d4[29:0], 2'b00} : d4;
        lz_lo[0] = !d2[31];
        n2_work.dn    = lz_lo[0] ? {d2[30:0], 1'b0} : d2;
        n2_work.rem   = u32dm_pkg::REM_SEED;
        n2_work.quo   = '0;
        n2_work.shift = ~{r1_lz, lz_lo};
        n2_work.pow2  = r1_pow2;
        n2_work.zero  = r1_zero;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
        end else begin
            if (ready1) begin
                r1_valid <= i_valid;
            end
            if (ready2) begin
                r2_valid <= r1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready1 && i_valid) begin
            r1_d    <= n1_d;
            r1_lz   <= n1_lz;
            r1_pow2 <= n1_pow2;
            r1_zero <= n1_zero;
        end
        if (ready2 && r1_valid) begin
            r2_work <= n2_work;
        end
    end

endmodule
`default_nettype wire

// ===== sv/u32dm_div_stage.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// u32dm_div_stage
// One register stage of the restoring divider: retires two quotient bits of
// 2^63 / dn per beat.
// ----------------------------------------------------------------------------
module u32dm_div_stage (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire u32dm_pkg::t_work i_work,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output u32dm_pkg::t_work      o_work
);

    logic             r_valid;
    u32dm_pkg::t_work r_work;
    u32dm_pkg::t_work n_work;
    logic             ready;

    assign ready   = !r_valid || i_ready;
    assign o_ready = ready;
    assign o_valid = r_valid;
    assign o_work  = r_work;

    always_comb begin
        logic [u32dm_pkg::WORD_W:0] trial;
        logic [u32dm_pkg::WORD_W:0] diff;
        logic                       ge;
        n_work = i_work;
        for (int k = 0; k < u32dm_pkg::DIV_BITS_PER_STAGE; k++) begin
            // Shift in a zero dividend bit, subtract when it fits
            trial      = {n_work.rem, 1'b0};
            diff       = trial - {1'b0, n_work.dn};
            ge         = (trial >= {1'b0, n_work.dn});
            n_work.rem = ge ? diff[u32dm_pkg::WORD_W-1:0] : trial[u32dm_pkg::WORD_W-1:0];
            n_work.quo = {n_work.quo[u32dm_pkg::WORD_W-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready && i_valid) begin
            r_work <= n_work;
        end
    end

endmodule
`default_nettype wire

// ===== sv/u32dm_finish.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// u32dm_finish
// Output stage: picks the plain or add-path magic from quotient and
// remainder, handles zero and power-of-two divisors, holds the result beat.
// ----------------------------------------------------------------------------
module u32dm_finish (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire u32dm_pkg::t_work i_work,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output u32dm_pkg::t_result    o_result
);

    logic                         r_valid;
    u32dm_pkg::t_result           r_result;
    u32dm_pkg::t_result           n_result;
    logic                         ready;
    logic [u32dm_pkg::WORD_W-1:0] err;
    logic [u32dm_pkg::WORD_W:0]   twice_rem;
    logic                         carry;
    logic                         big_err;
    logic [u32dm_pkg::WORD_W-1:0] base;

    assign ready    = !r_valid || i_ready;
    assign o_ready  = ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_comb begin
        // Remainder is scaled by 2^(31-s), so the 2^s bound becomes bit 31
        err       = i_work.dn - i_work.rem;
        big_err   = err[u32dm_pkg::WORD_W-1];
        twice_rem = {i_work.rem, 1'b0};
        carry     = (twice_rem >= {1'b0, i_work.dn});
        base      = big_err ? {i_work.quo[u32dm_pkg::WORD_W-2:0], carry} : i_work.quo;

        n_result.magic      = base + u32dm_pkg::WORD_W'(1);
        n_result.shift      = i_work.shift;
        n_result.add_marker = big_err;
        n_result.zero_error = 1'b0;
        if (i_work.zero) begin
            n_result.magic      = '0;
            n_result.shift      = '0;
            n_result.add_marker = 1'b0;
            n_result.zero_error = 1'b1;
        end else if (i_work.pow2) begin
            n_result.magic      = '0;
            n_result.add_marker = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready && i_valid) begin
            r_result <= n_result;
        end
    end

endmodule
`default_nettype wire

// ===== sv/u32_division_magic_generator.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// u32_division_magic_generator
// Prepares multiply-high magic constants for unsigned 32-bit division.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream carries one divisor per beat in i_s_tdata[31:0]. Master
//   stream returns one result beat per divisor, in order: magic, shift,
//   add marker and zero-divisor error packed into o_m_tdata.
//   An accepted beat passes through two normaliser stages (leading-zero
//   count and shift), sixteen divider stages retiring two quotient bits
//   each, and one output stage before it reaches o_m_tvalid.
//   Throughput is one divisor per cycle unless the receiver stalls; the two
//   chained 33-bit trial subtracts of each divider stage set the clock period.
//   Each stage advances on its own, so bubbles close up when the receiver
//   stalls and new divisors are still taken until the pipeline is full;
//   the output beat holds until taken. Reset empties the pipeline at once;
//   there is no start-up sweep.
// ----------------------------------------------------------------------------
module u32_division_magic_generator (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_s_tvalid,
    output logic                                     o_s_tready,
    // [31:0] divisor
    input  wire logic [u32dm_pkg::IN_TDATA_W-1:0]    i_s_tdata,
    output logic                                     o_m_tvalid,
    input  wire logic                                i_m_tready,
    // [31:0] magic, [36:32] shift, [37] add_marker, [38] zero_error, [39] pad
    output logic [u32dm_pkg::OUT_TDATA_W-1:0]        o_m_tdata
);

    localparam int N = u32dm_pkg::DIV_STAGE_COUNT;

    logic               valid [N+1];
    logic               ready [N+1];
    u32dm_pkg::t_work   work  [N+1];
    u32dm_pkg::t_result result;

    u32dm_norm u_norm (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_tvalid),
        .o_ready   (o_s_tready),
        .i_divisor (i_s_tdata[u32dm_pkg::WORD_W-1:0]),
        .o_valid   (valid[0]),
        .i_ready   (ready[0]),
        .o_work    (work[0])
    );

    for (genvar g = 0; g < N; g++) begin : g_div
        u32dm_div_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (valid[g]),
            .o_ready (ready[g]),
            .i_work  (work[g]),
            .o_valid (valid[g+1]),
            .i_ready (ready[g+1]),
            .o_work  (work[g+1])
        );
    end

    u32dm_finish u_finish (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (valid[N]),
        .o_ready  (ready[N]),
        .i_work   (work[N]),
        .o_valid  (o_m_tvalid),
        .i_ready  (i_m_tready),
        .o_result (result)
    );

    assign o_m_tdata = {1'b0, result.zero_error, result.add_marker,
                        result.shift, result.magic};

`ifndef NO_ASSERTIONS
    a_zero_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[38]) |-> (o_m_tdata[37:0] == '0))
        else $error("zero divisor result carries non-zero fields");

    a_add_not_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[37]) |-> !o_m_tdata[38])
        else $error("add marker set on zero divisor");

    a_stall_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> (o_m_tvalid && !i_m_tready))
        else $error("input stalled without an output stall");
`endif

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb - testbench for u32_division_magic_generator
// Streams divisors into the generator: a directed set of edge divisors, then
// random divisors with random gaps and back-pressure, one long output
// hold-off and drain pauses. Every result beat is checked field by field
// against an in-order queue of constants predicted here.
// ----------------------------------------------------------------------------
module tb;

    localparam int LONG_HOLD    = 200;
    localparam int RANDOM_ITEMS = 1040;
    localparam int FLUSH_CYCLES = 40;

    class magic_scoreboard;

        typedef struct {
            logic [u32dm_pkg::WORD_W-1:0] divisor;
            u32dm_pkg::t_result           res;
        } t_pending;

        t_pending pending_magic[$];
        int       mismatches;

        function new();
            mismatches = 0;
        endfunction

        // 2^(32+s)/d rounded up, or doubled with the add path when the
        // error term is too large; zero for zero and power-of-two divisors.
        function u32dm_pkg::t_result predict_magic(logic [u32dm_pkg::WORD_W-1:0] d);
            u32dm_pkg::t_result               res;
            logic [2*u32dm_pkg::WORD_W-1:0]   dividend;
            logic [u32dm_pkg::WORD_W-1:0]     quot;
            logic [u32dm_pkg::WORD_W-1:0]     rem;
            logic [u32dm_pkg::WORD_W-1:0]     err;
            logic [u32dm_pkg::WORD_W:0]       rem2;
            int unsigned                      lg;
            res = '0;
            lg  = 0;
            if (d == '0) begin
                res.zero_error = 1'b1;
            end else begin
                for (int b = 0; b < u32dm_pkg::WORD_W; b++) begin
                    if (d[b]) lg = b;
                end
                res.shift = lg[u32dm_pkg::SHIFT_W-1:0];
                if ((d & (d - 32'd1)) != '0) begin
                    dividend = 64'd1 << (u32dm_pkg::WORD_W + lg);
                    quot     = 32'(dividend / {32'd0, d});
                    rem      = 32'(dividend % {32'd0, d});
                    err      = d - rem;
                    if (err >= (32'd1 << lg)) begin
                        rem2 = {1'b0, rem} + {1'b0, rem};
                        quot = {quot[u32dm_pkg::WORD_W-2:0], 1'b0}
                             + ((rem2 >= {1'b0, d}) ? 32'd1 : 32'd0);
                        res.add_marker = 1'b1;
                    end
                    res.magic = quot + 32'd1;
                end
            end
            return res;
        endfunction

        function void note_divisor(logic [u32dm_pkg::WORD_W-1:0] d);
            t_pending p;
            p.divisor = d;
            p.res     = predict_magic(d);
            pending_magic.push_back(p);
        endfunction

        function void check_beat(logic [u32dm_pkg::OUT_TDATA_W-1:0] beat);
            t_pending p;
            if (pending_magic.size() == 0) begin
                $display("%0t: result beat with nothing pending: got %h", $time, beat);
                mismatches++;
                return;
            end
            p = pending_magic.pop_front();
            if (beat[31:0] !== p.res.magic) begin
                $display("%0t: divisor %h magic: expected %h, got %h",
                         $time, p.divisor, p.res.magic, beat[31:0]);
                mismatches++;
            end
            if (beat[36:32] !== p.res.shift) begin
                $display("%0t: divisor %h shift: expected %0d, got %0d",
                         $time, p.divisor, p.res.shift, beat[36:32]);
                mismatches++;
            end
            if (beat[37] !== p.res.add_marker) begin
                $display("%0t: divisor %h add_marker: expected %b, got %b",
                         $time, p.divisor, p.res.add_marker, beat[37]);
                mismatches++;
            end
            if (beat[38] !== p.res.zero_error) begin
                $display("%0t: divisor %h zero_error: expected %b, got %b",
                         $time, p.divisor, p.res.zero_error, beat[38]);
                mismatches++;
            end
            if (beat[39] !== 1'b0) begin
                $display("%0t: divisor %h pad bit: expected 0, got %b",
                         $time, p.divisor, beat[39]);
                mismatches++;
            end
        endfunction

    endclass

    logic                              i_clk = 1'b0;
    logic                              i_rst_n;
    logic                              i_s_tvalid;
    logic                              o_s_tready;
    logic [u32dm_pkg::IN_TDATA_W-1:0]  i_s_tdata;
    logic                              o_m_tvalid;
    logic                              i_m_tready;
    logic [u32dm_pkg::OUT_TDATA_W-1:0] o_m_tdata;

    magic_scoreboard sb = new();

    logic tx_free;
    logic rx_free;
    logic hold_req;

    u32_division_magic_generator DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [u32dm_pkg::WORD_W-1:0] pick_divisor();
        int unsigned k;
        k = $urandom_range(0, 31);
        case ($urandom_range(0, 7))
            0:       return $urandom;
            1:       return $urandom >> k;
            2:       return $urandom_range(1, 1024);
            3:       return 32'd1 << k;
            4:       return (32'd1 << k) + 32'd1;
            5:       return (32'd1 << k) - 32'd1;
            6:       return {1'b1, 31'($urandom)};
            default: return ($urandom_range(0, 3) == 0) ? 32'd0
                                                         : 32'hFFFF_FFFF - $urandom_range(0, 255);
        endcase
    endfunction

    task automatic send_divisor(input logic [u32dm_pkg::WORD_W-1:0] d);
        int unsigned gap;
        gap = tx_free ? 0 : pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            i_s_tvalid = 1'b0;
            i_s_tdata  = $urandom;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_s_tvalid = 1'b1;
        i_s_tdata  = d;
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_divisor(d);
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        i_s_tvalid = 1'b0;
        while (sb.pending_magic.size() != 0) @(posedge i_clk);
    endtask

    // Output side: random stalls, stall-free stretches, and the long hold-off.
    initial begin
        int unsigned stall_left;
        stall_left = 0;
        i_m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!i_rst_n) begin
                i_m_tready = 1'b0;
            end else if (hold_req) begin
                i_m_tready = 1'b0;
                repeat (LONG_HOLD - 1) @(negedge i_clk);
                hold_req   = 1'b0;
                stall_left = 0;
            end else if (rx_free) begin
                i_m_tready = 1'b1;
            end else if (stall_left > 0) begin
                i_m_tready = 1'b0;
                stall_left--;
            end else begin
                i_m_tready = 1'b1;
                if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) sb.check_beat(o_m_tdata);
    end

    initial begin
        logic [u32dm_pkg::WORD_W-1:0] edge_divisors[$];
        int                           sent;
        int                           phase_len;
        logic                         pressure_done;
        edge_divisors = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd5, 32'd6, 32'd7, 32'd10,
                          32'd25, 32'd100, 32'd641, 32'd1000, 32'h0001_0001,
                          32'h4000_0001, 32'h5555_5555, 32'h7FFF_FFFF,
                          32'h8000_0000, 32'h8000_0001, 32'hAAAA_AAAA,
                          32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'd0};
        i_rst_n       = 1'b0;
        i_s_tvalid    = 1'b0;
        i_s_tdata     = '0;
        tx_free       = 1'b0;
        rx_free       = 1'b0;
        hold_req      = 1'b0;
        pressure_done = 1'b0;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (edge_divisors[i]) send_divisor(edge_divisors[i]);
        drain_results();

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            phase_len = $urandom_range(60, 140);
            tx_free   = ($urandom_range(0, 3) == 0);
            rx_free   = ($urandom_range(0, 3) == 0);
            // Hold the output long enough for the pipeline to fill and
            // push back on the input.
            if (!pressure_done && sent > RANDOM_ITEMS / 3) begin
                tx_free  = 1'b1;
                hold_req = 1'b1;
                pressure_done = 1'b1;
            end
            repeat (phase_len) begin
                send_divisor(pick_divisor());
                sent++;
            end
            if ($urandom_range(0, 2) == 0) drain_results();
        end

        drain_results();
        repeat (FLUSH_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending_magic.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/u32dm_pkg.sv
sv/u32dm_norm.sv
sv/u32dm_div_stage.sv
sv/u32dm_finish.sv
sv/u32_division_magic_generator.sv
tb/tb.sv
